FILE: hdl/llap_pkg.sv
package llap_pkg;

   // Field widths of the streams and the configuration port.
   localparam int unsigned TimeWidth    = 32;
   localparam int unsigned RawWidth     = 16;
   localparam int unsigned LuxWidth     = 16;
   localparam int unsigned PercentWidth = 24;
   localparam int unsigned CsrIdxWidth  = 8;
   localparam int unsigned CsrDataWidth = 32;
   localparam int unsigned ReqDataWidth = 48;
   localparam int unsigned RspDataWidth = 40;

   // Lux conversion: floor(raw * 5 / 6) as (raw * 5) * ceil(2^21 / 6) >> 21.
   // The product stays exact for every 19-bit value of raw * 5.
   localparam int unsigned Raw5Width  = 19;
   localparam int unsigned ProdWidth  = 38;
   localparam int unsigned LuxShift   = 21;
   localparam logic [Raw5Width-1:0] LuxRecip = 19'd349526;

   // Scale and bound arithmetic.
   localparam int unsigned DiffWidth = LuxWidth + 1;
   localparam logic [PercentWidth-1:0] PercentScale = 24'd100;

   // Restoring divider.
   localparam int unsigned DivSteps      = PercentWidth;
   localparam int unsigned DivCountWidth = $clog2(DivSteps + 1);
   localparam int unsigned DivisorWidth  = LuxWidth;

   // Reset values.
   localparam logic [LuxWidth-1:0] LuxAllOnes = '1;

   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_REFRESH_PERIOD = 8'd0,
      CSR_AUTOLEVEL      = 8'd1,
      CSR_FIXED_MIN      = 8'd2,
      CSR_FIXED_MAX      = 8'd3
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_TIME,
      ST_GATE,
      ST_LUX,
      ST_BOUND,
      ST_PREP,
      ST_DIV,
      ST_OUT
   } state_type;

endpackage

FILE: hdl/light_level_autorange_percent.sv
// Light level autoranging to a percent scale.
// The req stream carries one sample per transfer: tdata holds now_ms in
// bits 31:0 and raw_count in bits 47:32. A sample taken less than the
// refresh period after the last accepted one is dropped without a result.
// Otherwise the count is converted to lux, the tracked bounds are widened
// when autolevel is on, and one rsp transfer follows with the percent level
// (bits 23:0, signed), the lux value (bits 39:24) and the zero span flag
// in tuser. The csr channel is always ready and writes a register per
// transfer. The user must write it only while the block is idle; the
// block itself does not enforce this. One sample is handled at a time
// and req_tready is low while it is in work. A dropped sample returns
// the block to idle. The percent level of an accepted sample comes from
// the radix-2 divider, which is skipped when the span is zero. The next
// sample is taken the cycle after the result transfer. The result waits
// in the output register while the receiver stalls, and no new sample
// is taken until it is transferred. Synchronous reset clears the
// registers to their reset values, the tracked bounds to an empty range
// and the last sample time to zero.
module light_level_autorange_percent (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // now_ms [31:0], raw_count [47:32]
   input  logic [llap_pkg::ReqDataWidth-1:0]     req_tdata,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // percent_level [23:0], lux_level [39:24]
   output logic [llap_pkg::RspDataWidth-1:0]     rsp_tdata,
   // zero_span [0]
   output logic                                  rsp_tuser,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [llap_pkg::CsrIdxWidth-1:0]      csr_index,
   input  logic [llap_pkg::CsrDataWidth-1:0]     csr_data
);

   llap_pkg::state_type state_ff, state_in;

   logic [llap_pkg::TimeWidth-1:0]    refresh_ff, refresh_in;
   logic                              auto_ff, auto_in;
   logic [llap_pkg::LuxWidth-1:0]     fixed_min_ff, fixed_min_in;
   logic [llap_pkg::LuxWidth-1:0]     fixed_max_ff, fixed_max_in;

   logic [llap_pkg::TimeWidth-1:0]    last_ff, last_in;
   logic [llap_pkg::LuxWidth-1:0]     tmin_ff, tmin_in;
   logic [llap_pkg::LuxWidth-1:0]     tmax_ff, tmax_in;

   logic [llap_pkg::TimeWidth-1:0]    now_ff, now_in;
   logic [llap_pkg::RawWidth-1:0]     raw_ff, raw_in;
   logic [llap_pkg::TimeWidth-1:0]    elapsed_ff, elapsed_in;
   logic [llap_pkg::ProdWidth-1:0]    prod_ff, prod_in;
   logic [llap_pkg::LuxWidth-1:0]     lux_ff, lux_in;
   logic [llap_pkg::DiffWidth-1:0]    num_ff, num_in;
   logic [llap_pkg::DiffWidth-1:0]    den_ff, den_in;
   logic                              neg_ff, neg_in;
   logic [llap_pkg::PercentWidth-1:0] pct_ff, pct_in;
   logic                              zero_ff, zero_in;

   logic [llap_pkg::Raw5Width-1:0]    raw5;
   logic [llap_pkg::LuxWidth-1:0]     lo, hi, new_min, new_max;
   logic [llap_pkg::DiffWidth-1:0]    num_abs, den_abs;
   logic                              div_start;
   logic [llap_pkg::PercentWidth-1:0] div_dividend;
   logic [llap_pkg::DivisorWidth-1:0] div_divisor;
   logic                              div_done;
   logic [llap_pkg::PercentWidth-1:0] div_quotient;

   llap_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   always_comb begin
      state_in     = state_ff;
      refresh_in   = refresh_ff;
      auto_in      = auto_ff;
      fixed_min_in = fixed_min_ff;
      fixed_max_in = fixed_max_ff;
      last_in      = last_ff;
      tmin_in      = tmin_ff;
      tmax_in      = tmax_ff;
      now_in       = now_ff;
      raw_in       = raw_ff;
      elapsed_in   = elapsed_ff;
      prod_in      = prod_ff;
      lux_in       = lux_ff;
      num_in       = num_ff;
      den_in       = den_ff;
      neg_in       = neg_ff;
      pct_in       = pct_ff;
      zero_in      = zero_ff;
      div_start    = 1'b0;

      raw5 = {1'b0, raw_ff, 2'b00} + {3'b000, raw_ff};

      new_max = (lux_ff > tmax_ff) ? lux_ff : tmax_ff;
      new_min = (lux_ff < tmin_ff) ? lux_ff : tmin_ff;
      lo      = auto_ff ? new_min : fixed_min_ff;
      hi      = auto_ff ? new_max : fixed_max_ff;

      num_abs = num_ff[llap_pkg::DiffWidth-1] ? (~num_ff + 1'b1) : num_ff;
      den_abs = den_ff[llap_pkg::DiffWidth-1] ? (~den_ff + 1'b1) : den_ff;
      div_dividend = {8'h00, num_abs[llap_pkg::LuxWidth-1:0]} * llap_pkg::PercentScale;
      div_divisor  = den_abs[llap_pkg::DivisorWidth-1:0];

      if (csr_valid) begin
         case (csr_index)
            llap_pkg::CSR_REFRESH_PERIOD: refresh_in = csr_data;
            llap_pkg::CSR_AUTOLEVEL:      auto_in = csr_data[0];
            llap_pkg::CSR_FIXED_MIN:      fixed_min_in = csr_data[llap_pkg::LuxWidth-1:0];
            llap_pkg::CSR_FIXED_MAX:      fixed_max_in = csr_data[llap_pkg::LuxWidth-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         llap_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               now_in   = req_tdata[llap_pkg::TimeWidth-1:0];
               raw_in   = req_tdata[llap_pkg::ReqDataWidth-1:llap_pkg::TimeWidth];
               state_in = llap_pkg::ST_TIME;
            end
         end
         llap_pkg::ST_TIME: begin
            // The elapsed time wraps, so a time stamp that moves backward
            // reads as a long gap.
            elapsed_in = now_ff - last_ff;
            state_in   = llap_pkg::ST_GATE;
         end
         llap_pkg::ST_GATE: begin
            if (elapsed_ff < refresh_ff) begin
               state_in = llap_pkg::ST_IDLE;
            end else begin
               last_in  = now_ff;
               prod_in  = {19'd0, raw5} * {19'd0, llap_pkg::LuxRecip};
               state_in = llap_pkg::ST_LUX;
            end
         end
         llap_pkg::ST_LUX: begin
            lux_in   = prod_ff[llap_pkg::LuxShift +: llap_pkg::LuxWidth];
            state_in = llap_pkg::ST_BOUND;
         end
         llap_pkg::ST_BOUND: begin
            if (auto_ff) begin
               tmin_in = new_min;
               tmax_in = new_max;
            end
            num_in   = {1'b0, lux_ff} - {1'b0, lo};
            den_in   = {1'b0, hi} - {1'b0, lo};
            state_in = llap_pkg::ST_PREP;
         end
         llap_pkg::ST_PREP: begin
            neg_in = num_ff[llap_pkg::DiffWidth-1] ^ den_ff[llap_pkg::DiffWidth-1];
            if (den_ff == '0) begin
               pct_in   = '0;
               zero_in  = 1'b1;
               state_in = llap_pkg::ST_OUT;
            end else begin
               zero_in   = 1'b0;
               div_start = 1'b1;
               state_in  = llap_pkg::ST_DIV;
            end
         end
         llap_pkg::ST_DIV: begin
            if (div_done) begin
               pct_in   = neg_ff ? (~div_quotient + 1'b1) : div_quotient;
               state_in = llap_pkg::ST_OUT;
            end
         end
         llap_pkg::ST_OUT: begin
            if (rsp_tready) begin
               state_in = llap_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = llap_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= llap_pkg::ST_IDLE;
         refresh_ff   <= '0;
         auto_ff      <= 1'b0;
         fixed_min_ff <= '0;
         fixed_max_ff <= llap_pkg::LuxAllOnes;
         last_ff      <= '0;
         tmin_ff      <= llap_pkg::LuxAllOnes;
         tmax_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         refresh_ff   <= refresh_in;
         auto_ff      <= auto_in;
         fixed_min_ff <= fixed_min_in;
         fixed_max_ff <= fixed_max_in;
         last_ff      <= last_in;
         tmin_ff      <= tmin_in;
         tmax_ff      <= tmax_in;
      end
      now_ff     <= now_in;
      raw_ff     <= raw_in;
      elapsed_ff <= elapsed_in;
      prod_ff    <= prod_in;
      lux_ff     <= lux_in;
      num_ff     <= num_in;
      den_ff     <= den_in;
      neg_ff     <= neg_in;
      pct_ff     <= pct_in;
      zero_ff    <= zero_in;
   end

   assign req_tready = (state_ff == llap_pkg::ST_IDLE);
   assign rsp_tvalid = (state_ff == llap_pkg::ST_OUT);
   assign rsp_tdata  = {lux_ff, pct_ff};
   assign rsp_tuser  = zero_ff;
   assign csr_ready  = 1'b1;

endmodule

FILE: hdl/llap_div.sv
module llap_div (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic [llap_pkg::PercentWidth-1:0]     dividend,
   input  logic [llap_pkg::DivisorWidth-1:0]     divisor,
   output logic                                  done,
   output logic [llap_pkg::PercentWidth-1:0]     quotient
);

   logic [llap_pkg::DivCountWidth-1:0] count_ff, count_in;
   logic                               done_ff, done_in;
   logic [llap_pkg::PercentWidth-1:0]  dvd_ff, dvd_in;
   logic [llap_pkg::DivisorWidth-1:0]  rem_ff, rem_in;
   logic [llap_pkg::DivisorWidth-1:0]  div_ff, div_in;
   logic [llap_pkg::DivisorWidth:0]    shifted;
   logic [llap_pkg::DivisorWidth+1:0]  trial;
   logic                               borrow;

   always_comb begin
      count_in = count_ff;
      done_in  = 1'b0;
      dvd_in   = dvd_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      // One quotient bit per cycle: shift in the next dividend bit and try
      // to subtract the divisor from the partial remainder.
      shifted  = {rem_ff, dvd_ff[llap_pkg::PercentWidth-1]};
      trial    = {1'b0, shifted} - {2'b00, div_ff};
      borrow   = trial[llap_pkg::DivisorWidth+1];
      if (start) begin
         count_in = llap_pkg::DivCountWidth'(llap_pkg::DivSteps);
         dvd_in   = dividend;
         rem_in   = '0;
         div_in   = divisor;
      end else if (count_ff != '0) begin
         count_in = count_ff - 1'b1;
         dvd_in   = {dvd_ff[llap_pkg::PercentWidth-2:0], ~borrow};
         rem_in   = borrow ? shifted[llap_pkg::DivisorWidth-1:0]
                           : trial[llap_pkg::DivisorWidth-1:0];
         done_in  = (count_ff == llap_pkg::DivCountWidth'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         done_ff  <= done_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign done     = done_ff;
   assign quotient = dvd_ff;

endmodule
